// File: rtl/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;

	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int DATA_W  = 36;   // CORDIC x/y datapath width
	localparam int ANGLE_W = 34;   // Q30 angle accumulator width
	localparam int SUM_W   = 34;   // unnormalized matrix term width
	localparam int NORM_W  = 33;   // squared norm width
	localparam int SH_W    = 6;

	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = ANGLE_W'(64'sd1686629713);
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
	localparam logic signed [16:0] LIM_FULL = 17'sd25736;
	localparam logic signed [16:0] LIM_HALF = 17'sd12868;

	localparam logic [29:0] ATAN_Q30 [32] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
		30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
		30'h00000001, 30'h00000000
	};

	// Q30 radians to Q13 with round half up, then clamp to +/- lim.
	function automatic logic signed [16:0] to_q13(input logic signed [ANGLE_W-1:0] z,
		input logic signed [16:0] lim);
		logic signed [ANGLE_W:0] t;
		logic signed [ANGLE_W-17:0] r;
		logic signed [16:0] o;
		t = {z[ANGLE_W-1], z} + (ANGLE_W+1)'(65536);
		r = t[ANGLE_W:17];
		if (r > (ANGLE_W-16)'(lim)) begin
			o = lim;
		end else if (r < -(ANGLE_W-16)'(lim)) begin
			o = -lim;
		end else begin
			o = 17'(r);
		end
		return o;
	endfunction

endpackage

// File: rtl/qte_if.sv
`timescale 1ns / 1ps
interface qte_quat_if;
	logic valid;
	logic ready;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_euler_if;
	logic valid;
	logic ready;
	logic signed [15:0] angle_x;
	logic signed [14:0] angle_y;
	logic signed [15:0] angle_z;
	logic degenerate;
	modport source (output valid, angle_x, angle_y, angle_z, degenerate, input ready);
	modport sink (input valid, angle_x, angle_y, angle_z, degenerate, output ready);
endinterface

// File: rtl/qte_cell.sv
`timescale 1ns / 1ps
module qte_cell import qte_pkg::*; #(
	parameter int SHIFT = 0,
	parameter int SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic signed [DATA_W-1:0] x_in,
	input  logic signed [DATA_W-1:0] y_in,
	input  logic signed [ANGLE_W-1:0] z_in,
	input  logic [SW-1:0] side_in,
	output logic signed [DATA_W-1:0] x_q,
	output logic signed [DATA_W-1:0] y_q,
	output logic signed [ANGLE_W-1:0] z_q,
	output logic [SW-1:0] side_q
);

	localparam logic signed [ANGLE_W-1:0] STEP =
		$signed({{(ANGLE_W-30){1'b0}}, ATAN_Q30[SHIFT]});

	logic signed [DATA_W-1:0] dx, dy;

	assign dx = y_in >>> SHIFT;
	assign dy = x_in >>> SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[DATA_W-1]) begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + STEP;
			end else begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - STEP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_in;
		end
	end

endmodule

// File: rtl/qte_cordic.sv
`timescale 1ns / 1ps
module qte_cordic import qte_pkg::*; #(
	parameter int ITER = CORDIC_ITERATIONS_DEF,
	parameter int SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic signed [DATA_W-1:0] x_in,
	input  logic signed [DATA_W-1:0] y_in,
	input  logic [SW-1:0] side_in,
	output logic signed [ANGLE_W-1:0] angle,
	output logic signed [DATA_W-1:0] mag,
	output logic is_zero,
	output logic [SW-1:0] side_out
);

	logic signed [DATA_W-1:0] xs [ITER+1];
	logic signed [DATA_W-1:0] ys [ITER+1];
	logic signed [ANGLE_W-1:0] zs [ITER+1];
	logic [SW:0] ss [ITER+1];

	logic signed [DATA_W-1:0] xp, yp;
	logic signed [ANGLE_W-1:0] zp;

	// Turn a left-half-plane vector into the right half plane first.
	always_comb begin
		xp = x_in;
		yp = y_in;
		zp = '0;
		if (x_in[DATA_W-1]) begin
			if (!y_in[DATA_W-1]) begin
				xp = y_in;
				yp = -x_in;
				zp = HALF_PI_Q30;
			end else begin
				xp = -y_in;
				yp = x_in;
				zp = -HALF_PI_Q30;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xs[0] <= xp;
			ys[0] <= yp;
			zs[0] <= zp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss[0] <= '0;
		end else if (en) begin
			ss[0] <= {(x_in == '0) && (y_in == '0), side_in};
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_cell
		qte_cell #(.SHIFT(i), .SW(SW+1)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]), .side_in(ss[i]),
			.x_q(xs[i+1]), .y_q(ys[i+1]), .z_q(zs[i+1]), .side_q(ss[i+1])
		);
	end

	assign angle = zs[ITER];
	assign mag = xs[ITER];
	assign is_zero = ss[ITER][SW];
	assign side_out = ss[ITER][SW-1:0];

endmodule

// File: rtl/qte_front.sv
`timescale 1ns / 1ps
module qte_front import qte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [15:0] qx,
	input  logic signed [15:0] qy,
	input  logic signed [15:0] qz,
	input  logic signed [15:0] qw,
	output logic valid_s4,
	output logic degen_s4,
	output logic signed [DATA_W-1:0] n0_s4,
	output logic signed [DATA_W-1:0] n3_s4,
	output logic signed [DATA_W-1:0] n4_s4,
	output logic signed [DATA_W-1:0] n5_s4,
	output logic signed [DATA_W-1:0] n6_s4
);

	logic v_s1, v_s2, v_s3;
	logic signed [31:0] sqx_s1, sqy_s1, sqz_s1, sqw_s1;
	logic signed [31:0] pxy_s1, pzw_s1, pxz_s1, pyw_s1, pyz_s1, pxw_s1;
	logic [NORM_W-1:0] snorm_s2;
	logic signed [SUM_W-1:0] n0_s2, n3_s2, n4_s2, n5_s2, n6_s2;
	logic signed [SUM_W-1:0] n0_s3, n3_s3, n4_s3, n5_s3, n6_s3;
	logic degen_s2, degen_s3;
	logic [SH_W-1:0] sh_s3, sh_c;
	logic signed [SUM_W-1:0] ssum;

	function automatic logic signed [SUM_W-1:0] ext(input logic signed [31:0] v);
		return SUM_W'(v);
	endfunction

	always_comb begin
		ssum = ext(sqx_s1) + ext(sqy_s1) + ext(sqz_s1) + ext(sqw_s1);
	end

	// The shift is the number of doublings that keep the norm within 2^32.
	always_comb begin
		sh_c = '0;
		for (int k = 1; k <= 32; k++) begin
			sh_c = sh_c + SH_W'(snorm_s2 <= (NORM_W'(1) << (32 - k)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= qx * qx;
			sqy_s1 <= qy * qy;
			sqz_s1 <= qz * qz;
			sqw_s1 <= qw * qw;
			pxy_s1 <= qx * qy;
			pzw_s1 <= qz * qw;
			pxz_s1 <= qx * qz;
			pyw_s1 <= qy * qw;
			pyz_s1 <= qy * qz;
			pxw_s1 <= qx * qw;

			snorm_s2 <= ssum[NORM_W-1:0];
			degen_s2 <= (ssum == '0);
			n0_s2 <= ext(sqx_s1) - ext(sqy_s1) - ext(sqz_s1) + ext(sqw_s1);
			n4_s2 <= ext(sqy_s1) - ext(sqx_s1) - ext(sqz_s1) + ext(sqw_s1);
			n3_s2 <= (ext(pxy_s1) + ext(pzw_s1)) <<< 1;
			n6_s2 <= (ext(pxz_s1) - ext(pyw_s1)) <<< 1;
			n5_s2 <= (ext(pyz_s1) - ext(pxw_s1)) <<< 1;

			sh_s3 <= sh_c;
			degen_s3 <= degen_s2;
			n0_s3 <= n0_s2;
			n3_s3 <= n3_s2;
			n4_s3 <= n4_s2;
			n5_s3 <= n5_s2;
			n6_s3 <= n6_s2;

			degen_s4 <= degen_s3;
			n0_s4 <= DATA_W'(n0_s3) <<< sh_s3;
			n3_s4 <= DATA_W'(n3_s3) <<< sh_s3;
			n4_s4 <= DATA_W'(n4_s3) <<< sh_s3;
			n5_s4 <= DATA_W'(n5_s3) <<< sh_s3;
			n6_s4 <= DATA_W'(n6_s3) <<< sh_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			valid_s4 <= v_s3;
		end
	end

endmodule

// File: rtl/quaternion_to_euler.sv
`timescale 1ns / 1ps
// Path: front stages, x/z CORDIC rows, hypot multiply, y CORDIC row, output register.
// Throughput: one word per cycle; the CORDIC cell rows and the split hypot multiply
// are fully pipelined, so a new word enters every cycle the output is free or taken.
// A stalled output word holds the whole pipeline.
// Reset (arst_n low) clears all valid flags; datapath registers are not reset.
module quaternion_to_euler import qte_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	qte_quat_if.sink quat,
	qte_euler_if.source euler
);

	localparam int SA_W = DATA_W + 2;
	localparam int SB_W = 2 * ANGLE_W + 4;

	logic en;
	logic out_v_q;
	logic valid_s4, degen_s4;
	logic signed [DATA_W-1:0] n0_s4, n3_s4, n4_s4, n5_s4, n6_s4;

	logic signed [ANGLE_W-1:0] za, zc;
	logic signed [DATA_W-1:0] mag_a, mag_c;
	logic zero_a, zero_c;
	logic [SA_W-1:0] side_a;
	logic side_c;

	logic v_m1, v_m2;
	logic degen_m1, degen_m2, zero_a_m1, zero_a_m2, zero_c_m1, zero_c_m2;
	logic signed [ANGLE_W-1:0] za_m1, za_m2, zc_m1, zc_m2;
	logic signed [DATA_W-1:0] n3_m1, n3_m2, h_m2;
	logic [46:0] ph_m1, pl_m1;
	logic [65:0] hsum;

	logic signed [ANGLE_W-1:0] zb;
	logic signed [DATA_W-1:0] mag_b;
	logic zero_b;
	logic [SB_W-1:0] side_b;

	logic signed [16:0] ax_c, ay_c, az_c;

	assign en = !out_v_q || euler.ready;
	assign quat.ready = en;

	qte_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(quat.valid && quat.ready),
		.qx(quat.quat_x), .qy(quat.quat_z), .qz(quat.quat_y), .qw(quat.quat_w),
		.valid_s4(valid_s4), .degen_s4(degen_s4),
		.n0_s4(n0_s4), .n3_s4(n3_s4), .n4_s4(n4_s4), .n5_s4(n5_s4), .n6_s4(n6_s4)
	);

	qte_cordic #(.ITER(CORDIC_ITERATIONS), .SW(SA_W)) u_cordic_x (
		.clk(clk), .arst_n(arst_n), .en(en), .x_in(n0_s4), .y_in(-n6_s4),
		.side_in({valid_s4, degen_s4, n3_s4}),
		.angle(za), .mag(mag_a), .is_zero(zero_a), .side_out(side_a)
	);

	qte_cordic #(.ITER(CORDIC_ITERATIONS), .SW(1)) u_cordic_z (
		.clk(clk), .arst_n(arst_n), .en(en), .x_in(n4_s4), .y_in(-n5_s4),
		.side_in(valid_s4),
		.angle(zc), .mag(mag_c), .is_zero(zero_c), .side_out(side_c)
	);

	// hypot(n0, n6) = CORDIC magnitude / K, done as two 17 x 30 partial products.
	assign hsum = {2'b00, ph_m1, 17'd0} + 66'(pl_m1) + (66'd1 << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			ph_m1 <= 47'(mag_a[33:17]) * 47'(INV_GAIN_Q30);
			pl_m1 <= 47'(mag_a[16:0]) * 47'(INV_GAIN_Q30);
			degen_m1 <= side_a[SA_W-2];
			n3_m1 <= side_a[DATA_W-1:0];
			za_m1 <= za;
			zc_m1 <= zc;
			zero_a_m1 <= zero_a;
			zero_c_m1 <= zero_c;

			h_m2 <= $signed(hsum[30+DATA_W-1:30]);
			degen_m2 <= degen_m1;
			n3_m2 <= n3_m1;
			za_m2 <= za_m1;
			zc_m2 <= zc_m1;
			zero_a_m2 <= zero_a_m1;
			zero_c_m2 <= zero_c_m1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
		end else if (en) begin
			v_m1 <= side_a[SA_W-1];
			v_m2 <= v_m1;
		end
	end

	qte_cordic #(.ITER(CORDIC_ITERATIONS), .SW(SB_W)) u_cordic_y (
		.clk(clk), .arst_n(arst_n), .en(en), .x_in(h_m2), .y_in(n3_m2),
		.side_in({v_m2, degen_m2, zero_a_m2, zero_c_m2, za_m2, zc_m2}),
		.angle(zb), .mag(mag_b), .is_zero(zero_b), .side_out(side_b)
	);

	// A zero vector inside an atan2 gives angle zero.
	always_comb begin
		ax_c = side_b[2*ANGLE_W+1] ? '0 : to_q13(side_b[2*ANGLE_W-1:ANGLE_W], LIM_FULL);
		az_c = side_b[2*ANGLE_W] ? '0 : to_q13(side_b[ANGLE_W-1:0], LIM_FULL);
		ay_c = zero_b ? '0 : to_q13(zb, LIM_HALF);
		if (side_b[SB_W-2]) begin
			ax_c = '0;
			ay_c = '0;
			az_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			euler.angle_x <= ax_c[15:0];
			euler.angle_y <= ay_c[14:0];
			euler.angle_z <= az_c[15:0];
			euler.degenerate <= side_b[SB_W-2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= side_b[SB_W-1];
		end
	end

	assign euler.valid = out_v_q;

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		side_c == side_a[SA_W-1])
		else $error("x and z CORDIC lanes out of step");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid && euler.degenerate |->
		euler.angle_x == '0 && euler.angle_y == '0 && euler.angle_z == '0)
		else $error("degenerate word with nonzero angles");

	a_angle_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid |-> euler.angle_y <= 15'sd12868 && euler.angle_y >= -15'sd12868)
		else $error("angle_y out of range");

	a_hypot_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v_m2 |-> !h_m2[DATA_W-1])
		else $error("negative hypot");

	a_mag_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(side_c |-> !mag_c[DATA_W-1]) and (side_b[SB_W-1] |-> !mag_b[DATA_W-1]))
		else $error("negative CORDIC magnitude");

endmodule
